// ===== hdl/wes_pkg.sv =====
// Shared types and constants for the wave equation stencil step block.
// Used by every module under hdl; depends on nothing.
`default_nettype none

package wes_pkg;

	// Fixed field widths
	localparam int VAL_W       = 32;
	localparam int COEF_W      = 24;
	localparam int GRID_SIZE_W = 11;
	localparam int CFG_W       = 24;
	localparam int POS_W       = 10;
	localparam int IDX_W       = 2;

	// Register reset values
	localparam int               GRID_RST  = 100;
	localparam logic [COEF_W-1:0] COEF_RST = 24'd41943;
	localparam logic             FIRST_RST = 1'b0;

	// Register indexes
	typedef logic [IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_GRID_SIZE   = 2'd0;
	localparam reg_idx_t REG_COEFFICIENT = 2'd1;
	localparam reg_idx_t REG_FIRST_STEP  = 2'd2;

	// Arithmetic types: sample, neighbor sum, update base, Laplacian, product
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [33:0]      nsum_t;
	typedef logic signed [33:0]      base_t;
	typedef logic signed [34:0]      lap_t;
	typedef logic signed [59:0]      prod_t;
	typedef logic [POS_W-1:0]        pos_t;
	typedef logic [COEF_W-1:0]       coef_t;

	localparam prod_t SAT_HI = prod_t'(64'sd2147483647);
	localparam prod_t SAT_LO = prod_t'(-64'sd2147483648);

	// Per-request control decoded at acceptance
	typedef struct packed {
		logic sample;    // writes the line memory
		logic emit;      // produces a result
		logic interior;  // stencil cell, otherwise the result is zero
		logic last;      // final cell of the frame
		pos_t row;
		pos_t col;
	} item_ctl_t;

	// One line memory word: current row, row above, previous-step sample
	typedef struct packed {
		val_t row1;
		val_t row2;
		val_t prev;
	} line_word_t;

	// Stencil operands handed to the datapath
	typedef struct packed {
		val_t up;
		val_t centre;
		val_t left;
		val_t right;
		val_t prev;
	} nbr_t;

endpackage

`default_nettype wire

// ===== hdl/wes_ctrl.sv =====
// Configuration registers, raster counters and per-request decode.
// Depends on wes_pkg.
`default_nettype none

module wes_ctrl #(
	parameter int GRID_MAX = 1024,
	parameter int CW       = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        fire,
	input  wire logic                        is_flush,
	input  wire logic                        cfg_we,
	input  wire wes_pkg::reg_idx_t           cfg_index,
	input  wire logic [wes_pkg::CFG_W-1:0]   cfg_wdata,
	output wes_pkg::item_ctl_t               ctl,
	output logic [CW-1:0]                    rd_col,
	output logic [CW-1:0]                    wr_col,
	output wes_pkg::coef_t                   coefficient,
	output logic                             first_step
);

	localparam int NRst = (wes_pkg::GRID_RST > GRID_MAX) ? GRID_MAX : wes_pkg::GRID_RST;

	logic [CW-1:0] nm1_q;
	logic [CW-1:0] nm1_new;
	logic [31:0]   g32;
	wes_pkg::coef_t coef_q;
	logic          first_q;

	logic [CW-1:0] in_row_q, in_col_q, out_row_q, out_col_q;
	logic          in_full_q;

	logic take_sample, take_flush, emit;
	logic in_col_last, in_row_last, out_col_last, frame_end;

	// Clamp the written grid size to [3, GRID_MAX], kept as N-1
	always_comb begin
		g32 = 32'(cfg_wdata[wes_pkg::GRID_SIZE_W-1:0]);
		if (g32 < 32'd3) begin
			nm1_new = CW'(2);
		end else if (g32 > 32'(GRID_MAX)) begin
			nm1_new = CW'(GRID_MAX - 1);
		end else begin
			nm1_new = CW'(g32 - 32'd1);
		end
	end

	// Request decode
	always_comb begin
		take_sample  = !is_flush && !in_full_q;
		take_flush   = is_flush && in_full_q;
		emit         = (take_sample && (in_row_q != '0)) || take_flush;
		in_col_last  = (in_col_q == nm1_q);
		in_row_last  = (in_row_q == nm1_q);
		out_col_last = (out_col_q == nm1_q);
		frame_end    = emit && out_col_last && (out_row_q == nm1_q);

		ctl.sample   = take_sample;
		ctl.emit     = emit;
		ctl.interior = take_sample && (out_row_q != '0) && (out_row_q != nm1_q)
			&& (out_col_q != '0) && (out_col_q != nm1_q);
		ctl.last     = out_col_last && (out_row_q == nm1_q);
		ctl.row      = wes_pkg::pos_t'(out_row_q);
		ctl.col      = wes_pkg::pos_t'(out_col_q);

		// next column of the line memory; wraps so column 0 is preloaded
		rd_col = in_col_last ? '0 : in_col_q + CW'(1);
		wr_col = in_col_q;
	end

	// Registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nm1_q     <= CW'(NRst - 1);
			coef_q    <= wes_pkg::COEF_RST;
			first_q   <= wes_pkg::FIRST_RST;
			in_row_q  <= '0;
			in_col_q  <= '0;
			in_full_q <= 1'b0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wes_pkg::REG_GRID_SIZE: begin
					nm1_q     <= nm1_new;
					in_row_q  <= '0;
					in_col_q  <= '0;
					in_full_q <= 1'b0;
					out_row_q <= '0;
					out_col_q <= '0;
				end
				wes_pkg::REG_COEFFICIENT: coef_q <= cfg_wdata[wes_pkg::COEF_W-1:0];
				wes_pkg::REG_FIRST_STEP: first_q <= cfg_wdata[0];
				default: ;
			endcase
		end else if (fire) begin
			if (take_sample) begin
				if (in_col_last) begin
					in_col_q <= '0;
					if (in_row_last) begin
						in_full_q <= 1'b1;
					end else begin
						in_row_q <= in_row_q + CW'(1);
					end
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (emit) begin
				if (out_col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + CW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
			// final cell leaves: a new frame starts
			if (frame_end) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				in_full_q <= 1'b0;
				out_row_q <= '0;
				out_col_q <= '0;
			end
		end
	end

	assign coefficient = coef_q;
	assign first_step  = first_q;

endmodule

`default_nettype wire

// ===== hdl/wes_line_mem.sv =====
// Line memory of the current field and the three-column stencil window.
// Depends on wes_pkg.
`default_nettype none

module wes_line_mem #(
	parameter int GRID_MAX = 1024,
	parameter int CW       = 10
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [CW-1:0] rd_col,
	input  wire logic          wr_en,
	input  wire logic [CW-1:0] wr_col,
	input  wire wes_pkg::val_t cur,
	input  wire wes_pkg::val_t prv,
	output wes_pkg::nbr_t      nbr
);

	// One word per column: this row, the row above, previous-step sample
	wes_pkg::line_word_t mem [GRID_MAX];
	wes_pkg::line_word_t rd_q;     // column c+1
	wes_pkg::line_word_t win_c_q;  // column c
	wes_pkg::val_t       win_l_q;  // column c-1, centre row only

	// Read ahead at acceptance, write back as the request leaves stage 1.
	// Read and write addresses never fall on the same column.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_col] <= '{row1: cur, row2: win_c_q.row1, prev: prv};
		end
		if (rd_en) begin
			rd_q <= mem[rd_col];
		end
	end

	// Window slides one column per written sample
	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_l_q <= win_c_q.row1;
			win_c_q <= rd_q;
		end
	end

	always_comb begin
		nbr.up     = win_c_q.row2;
		nbr.centre = win_c_q.row1;
		nbr.left   = win_l_q;
		nbr.right  = rd_q.row1;
		nbr.prev   = win_c_q.prev;
	end

endmodule

`default_nettype wire

// ===== hdl/wes_datapath.sv =====
// Stencil arithmetic pipeline: neighbor sum, Laplacian, weight product,
// shift, saturate and output register. Depends on wes_pkg.
`default_nettype none

module wes_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire wes_pkg::item_ctl_t ctl,
	input  wire wes_pkg::val_t      down,
	input  wire wes_pkg::nbr_t      nbr,
	input  wire wes_pkg::coef_t     coefficient,
	input  wire logic               first_step,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output wes_pkg::val_t           new_value,
	output wes_pkg::pos_t           out_row,
	output wes_pkg::pos_t           out_col,
	output logic                    frame_last
);

	logic en2, en3, en4, en_o;

	logic               s2_v, s3_v, s4_v, out_v_q;
	wes_pkg::item_ctl_t ctl_s2, ctl_s3, ctl_s4;
	logic               first_s2, first_s3, first_s4;
	wes_pkg::nsum_t     nsum_s2;
	wes_pkg::val_t      centre_s2;
	wes_pkg::base_t     base_s2, base_s3, base_s4;
	wes_pkg::lap_t      lap_s3;
	wes_pkg::prod_t     prod_s4;

	wes_pkg::prod_t     coef_w, shifted, total;
	wes_pkg::val_t      sat;
	wes_pkg::val_t      value_q;
	wes_pkg::pos_t      row_q, col_q;
	logic               last_q;

	// Each stage moves when the next one is empty or moving
	assign en_o     = !out_v_q || result_ready;
	assign en4      = !s4_v || en_o;
	assign en3      = !s3_v || en4;
	assign en2      = !s2_v || en3;
	assign in_ready = en2;

	// Shift by the weight scale (half weight on the first step), saturate
	always_comb begin
		coef_w  = wes_pkg::prod_t'($signed({1'b0, coefficient}));
		shifted = first_s4 ? (prod_s4 >>> 25) : (prod_s4 >>> 24);
		total   = wes_pkg::prod_t'(base_s4) + shifted;
		if (total > wes_pkg::SAT_HI) begin
			sat = wes_pkg::val_t'(wes_pkg::SAT_HI);
		end else if (total < wes_pkg::SAT_LO) begin
			sat = wes_pkg::val_t'(wes_pkg::SAT_LO);
		end else begin
			sat = wes_pkg::val_t'(total);
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v    <= 1'b0;
			s3_v    <= 1'b0;
			s4_v    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en2) s2_v <= in_valid;
			if (en3) s3_v <= s2_v;
			if (en4) s4_v <= s3_v;
			if (en_o) out_v_q <= s4_v;
		end
	end

	// Stage 2: neighbor sum and update base
	always_ff @(posedge clk) begin
		if (en2 && in_valid) begin
			ctl_s2    <= ctl;
			first_s2  <= first_step;
			centre_s2 <= nbr.centre;
			nsum_s2   <= wes_pkg::nsum_t'(nbr.up) + wes_pkg::nsum_t'(down)
				+ wes_pkg::nsum_t'(nbr.left) + wes_pkg::nsum_t'(nbr.right);
			base_s2   <= first_step ? wes_pkg::base_t'(nbr.centre)
				: (wes_pkg::base_t'(nbr.centre) <<< 1) - wes_pkg::base_t'(nbr.prev);
		end
	end

	// Stage 3: Laplacian
	always_ff @(posedge clk) begin
		if (en3 && s2_v) begin
			ctl_s3   <= ctl_s2;
			first_s3 <= first_s2;
			base_s3  <= base_s2;
			lap_s3   <= wes_pkg::lap_t'(nsum_s2) - (wes_pkg::lap_t'(centre_s2) <<< 2);
		end
	end

	// Stage 4: weight product
	always_ff @(posedge clk) begin
		if (en4 && s3_v) begin
			ctl_s4   <= ctl_s3;
			first_s4 <= first_s3;
			base_s4  <= base_s3;
			prod_s4  <= wes_pkg::prod_t'(lap_s3) * coef_w;
		end
	end

	// Output register; border cells give zero
	always_ff @(posedge clk) begin
		if (en_o && s4_v) begin
			value_q <= ctl_s4.interior ? sat : '0;
			row_q   <= ctl_s4.row;
			col_q   <= ctl_s4.col;
			last_q  <= ctl_s4.last;
		end
	end

	assign result_valid = out_v_q;
	assign new_value    = value_q;
	assign out_row      = row_q;
	assign out_col      = col_q;
	assign frame_last   = last_q;

endmodule

`default_nettype wire

// ===== hdl/wave_equation_stencil_step_top.sv =====
// Top level of the streaming five-point wave equation stencil step.
// Depends on wes_pkg, wes_ctrl, wes_line_mem and wes_datapath.
`default_nettype none

// Takes one request per clock unless stalled: a current-field sample in
// raster order with the previous-step sample of the same cell, or a flush.
// The result for cell (r-1, c) comes from the sample of cell (r, c) via
// stage 1 and the datapath; after the N*N samples of a frame, N flush
// requests release the last (border) row. The rate of one cell per cycle is
// set by the line memory, which does one read-ahead of the next column and
// one write-back per cell, with a three-column window in registers. Results
// wait in an output register while new requests keep flowing; result_ready
// low only stops the input once all five stages are full. The line memory
// needs no clearing pass: entries are always written before they are used.
// Write the registers only while no request is in flight.
module wave_equation_stencil_step_top #(
	parameter int GRID_MAX = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire wes_pkg::reg_idx_t         cfg_index,
	input  wire logic [wes_pkg::CFG_W-1:0] cfg_wdata,
	input  wire logic                      sample_valid,
	output logic                           sample_ready,
	input  wire logic                      is_flush,
	input  wire wes_pkg::val_t             current_value,
	input  wire wes_pkg::val_t             previous_value,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output wes_pkg::val_t                  new_value,
	output wes_pkg::pos_t                  out_row,
	output wes_pkg::pos_t                  out_col,
	output logic                           frame_last
);

	localparam int CW = $clog2(GRID_MAX);

	logic               fire;
	wes_pkg::item_ctl_t ctl;
	logic [CW-1:0]      rd_col, wr_col;
	wes_pkg::coef_t     coefficient;
	logic               first_step;

	logic               s1_v_q;
	wes_pkg::item_ctl_t s1_ctl_q;
	wes_pkg::val_t      s1_cur_q, s1_prv_q;
	logic [CW-1:0]      s1_col_q;
	logic               s1_go;
	logic               dp_ready;
	logic               lm_rd_en, lm_wr_en;
	wes_pkg::nbr_t      nbr;

	// Stage 1 leaves when it has no result or the datapath takes it
	assign s1_go        = !s1_ctl_q.emit || dp_ready;
	assign sample_ready = !s1_v_q || s1_go;
	assign fire         = sample_valid && sample_ready;
	assign lm_rd_en     = fire && ctl.sample;
	assign lm_wr_en     = s1_v_q && s1_ctl_q.sample && s1_go;

	wes_ctrl #(
		.GRID_MAX (GRID_MAX),
		.CW       (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.is_flush    (is_flush),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.ctl         (ctl),
		.rd_col      (rd_col),
		.wr_col      (wr_col),
		.coefficient (coefficient),
		.first_step  (first_step)
	);

	// Stage 1: request waits here for the line memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (sample_ready) begin
			s1_v_q <= fire && (ctl.sample || ctl.emit);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			s1_ctl_q <= ctl;
			s1_cur_q <= current_value;
			s1_prv_q <= previous_value;
			s1_col_q <= wr_col;
		end
	end

	wes_line_mem #(
		.GRID_MAX (GRID_MAX),
		.CW       (CW)
	) u_line_mem (
		.clk    (clk),
		.rd_en  (lm_rd_en),
		.rd_col (rd_col),
		.wr_en  (lm_wr_en),
		.wr_col (s1_col_q),
		.cur    (s1_cur_q),
		.prv    (s1_prv_q),
		.nbr    (nbr)
	);

	wes_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s1_v_q && s1_ctl_q.emit),
		.in_ready     (dp_ready),
		.ctl          (s1_ctl_q),
		.down         (s1_cur_q),
		.nbr          (nbr),
		.coefficient  (coefficient),
		.first_step   (first_step),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.new_value    (new_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.frame_last   (frame_last)
	);

`ifndef NO_ASSERTIONS
	// Read-ahead and write-back never hit the same column in one cycle
	a_mem_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(lm_rd_en && lm_wr_en) |-> (rd_col != s1_col_q))
		else $error("line memory read and write collide");

	// Top border row always comes out as zero
	a_top_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (out_row == '0)) |-> (new_value == '0))
		else $error("nonzero value on the top border row");

	// Frame end flag only on the diagonal corner cell
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && frame_last) |-> (out_row == out_col))
		else $error("frame_last off the corner cell");
`endif

endmodule

`default_nettype wire

// ===== test/tb_wave_equation_stencil_step_top.sv =====
// Self-checking testbench for the streaming five-point wave equation stencil step.
// Needs wes_pkg and wave_equation_stencil_step_top; a local field model predicts
// each result, and a valid/ready driver and monitor check it against the block.
`timescale 1ns / 100ps

module tb_wave_equation_stencil_step_top;

	localparam int GRID_MAX      = 1024;
	localparam int RANDOM_ITEMS  = 400;
	localparam int SETTLE_CYCLES = 12;
	localparam wes_pkg::val_t V_MAX = wes_pkg::val_t'(32'h7FFF_FFFF);
	localparam wes_pkg::val_t V_MIN = wes_pkg::val_t'(32'h8000_0000);

	// One request to the block and one expected result
	typedef struct packed {
		logic          flush;
		wes_pkg::val_t cur;
		wes_pkg::val_t prv;
	} wave_req_t;

	typedef struct packed {
		wes_pkg::val_t value;
		wes_pkg::pos_t row;
		wes_pkg::pos_t col;
		logic          last;
	} cell_t;

	// Receiver stall patterns
	typedef enum logic [1:0] {RX_OPEN, RX_SKIP4, RX_COIN, RX_BLOCK} rx_mode_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      cfg_we       = 1'b0;
	wes_pkg::reg_idx_t         cfg_index    = wes_pkg::REG_GRID_SIZE;
	logic [wes_pkg::CFG_W-1:0] cfg_wdata    = '0;
	logic                      sample_valid = 1'b0;
	logic                      sample_ready;
	logic                      is_flush       = 1'b0;
	wes_pkg::val_t             current_value  = '0;
	wes_pkg::val_t             previous_value = '0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	wes_pkg::val_t             new_value;
	wes_pkg::pos_t             out_row;
	wes_pkg::pos_t             out_col;
	logic                      frame_last;

	wave_equation_stencil_step_top #(.GRID_MAX(GRID_MAX)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.is_flush       (is_flush),
		.current_value  (current_value),
		.previous_value (previous_value),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.new_value      (new_value),
		.out_row        (out_row),
		.out_col        (out_col),
		.frame_last     (frame_last)
	);

	always #2 clk = ~clk;

	// Field model: two rows of the current field, previous field one row back
	wes_pkg::val_t  field_rows [2][GRID_MAX];
	wes_pkg::val_t  prev_line [GRID_MAX];
	int unsigned    cells_taken = 0;
	int unsigned    cells_sent  = 0;
	logic [10:0]    grid_cfg    = 11'(wes_pkg::GRID_RST);
	wes_pkg::coef_t coef_cfg    = wes_pkg::COEF_RST;
	logic           first_cfg   = wes_pkg::FIRST_RST;

	wave_req_t    req_queue[$];
	cell_t        cell_queue[$];
	int           mismatches   = 0;
	int           random_items = 0;

	function automatic int unsigned grid_used();
		if (grid_cfg < 11'd3)
			return 3;
		if (grid_cfg > 11'(GRID_MAX))
			return GRID_MAX;
		return grid_cfg;
	endfunction

	task automatic push_cell(input int unsigned n, input int unsigned row,
			input int unsigned col, input wes_pkg::val_t value);
		cell_t res;
		res.value = value;
		res.row   = wes_pkg::pos_t'(row);
		res.col   = wes_pkg::pos_t'(col);
		res.last  = (row == n - 1 && col == n - 1);
		cell_queue.push_back(res);
		cells_sent++;
		if (cells_sent >= n * n) begin
			cells_sent  = 0;
			cells_taken = 0;
		end
	endtask

	// Advance the field model by one accepted request
	task automatic step_field(input wave_req_t rq);
		int unsigned n, total, r, c, slot_now, slot_old;
		logic signed [63:0] up_v, down_v, left_v, right_v, centre_v, prev_v;
		logic signed [63:0] lap, coef64, prod, acc;
		wes_pkg::val_t value;
		n     = grid_used();
		total = n * n;
		if (rq.flush) begin
			// pending cells all lie on the last (border) row
			if (cells_taken < total || cells_sent >= total)
				return;
			push_cell(n, cells_sent / n, cells_sent % n, '0);
			return;
		end
		if (cells_taken >= total)
			return;
		r = cells_taken / n;
		c = cells_taken % n;
		slot_now = r % 2;
		slot_old = (r + 1) % 2;
		if (r >= 1) begin
			value = '0;
			if (r - 1 != 0 && r - 1 != n - 1 && c != 0 && c != n - 1) begin
				centre_v = field_rows[slot_old][c];
				left_v   = field_rows[slot_old][c - 1];
				right_v  = field_rows[slot_old][c + 1];
				up_v     = field_rows[slot_now][c];
				down_v   = rq.cur;
				prev_v   = prev_line[c];
				lap      = up_v + down_v + left_v + right_v - 4 * centre_v;
				coef64   = {40'd0, coef_cfg};
				prod     = lap * coef64;
				if (first_cfg)
					acc = centre_v + (prod >>> 25);
				else
					acc = 2 * centre_v - prev_v + (prod >>> 24);
				if (acc > 64'sd2147483647)
					acc = 64'sd2147483647;
				else if (acc < -64'sd2147483648)
					acc = -64'sd2147483648;
				value = acc[31:0];
			end
			push_cell(n, r - 1, c, value);
		end
		field_rows[slot_now][c] = rq.cur;
		prev_line[c] = rq.prv;
		cells_taken++;
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// Sender: bursts of random length with random gaps
	int        burst_left = 1;
	int        gap_left   = 0;
	wave_req_t held_req;
	wave_req_t next_req;

	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && sample_ready)
				step_field(held_req);
			if (!sample_valid || sample_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					sample_valid <= 1'b0;
				end else if (req_queue.size() > 0) begin
					next_req = req_queue.pop_front();
					held_req = next_req;
					sample_valid   <= 1'b1;
					is_flush       <= next_req.flush;
					current_value  <= next_req.cur;
					previous_value <= next_req.prv;
					burst_left--;
					if (burst_left <= 0) begin
						if ($urandom_range(0, 3) == 0) begin
							gap_left   = 0;
							burst_left = $urandom_range(20, 80);
						end else begin
							gap_left   = $urandom_range(1, 7);
							burst_left = $urandom_range(1, 12);
						end
					end
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern switches between a few shapes
	rx_mode_t    rx_mode   = RX_OPEN;
	int          mode_left = 0;
	int unsigned rx_tick   = 0;
	logic        rx_take;
	cell_t       exp_cell;

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (cell_queue.size() == 0) begin
					note_mismatch($sformatf("unexpected result row %0d col %0d value %0h",
						out_row, out_col, new_value));
				end else begin
					exp_cell = cell_queue.pop_front();
					if (new_value !== exp_cell.value)
						note_mismatch($sformatf("new_value at (%0d,%0d): got %0h want %0h",
							exp_cell.row, exp_cell.col, new_value, exp_cell.value));
					if (out_row !== exp_cell.row)
						note_mismatch($sformatf("out_row: got %0d want %0d",
							out_row, exp_cell.row));
					if (out_col !== exp_cell.col)
						note_mismatch($sformatf("out_col: got %0d want %0d",
							out_col, exp_cell.col));
					if (frame_last !== exp_cell.last)
						note_mismatch($sformatf("frame_last at (%0d,%0d): got %b want %b",
							exp_cell.row, exp_cell.col, frame_last, exp_cell.last));
				end
			end
			if (mode_left <= 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			rx_tick++;
			case (rx_mode)
				RX_OPEN:  rx_take = 1'b1;
				RX_SKIP4: rx_take = (rx_tick % 4) != 3;
				RX_COIN:  rx_take = 1'($urandom_range(0, 1));
				default:  rx_take = (rx_tick % 32) >= 20;
			endcase
			result_ready <= rx_take;
		end
	end

	// Register write; the model follows at once since the block is idle
	task automatic write_reg(input wes_pkg::reg_idx_t idx,
			input logic [wes_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			wes_pkg::REG_GRID_SIZE: begin
				grid_cfg    = data[10:0];
				cells_taken = 0;
				cells_sent  = 0;
			end
			wes_pkg::REG_COEFFICIENT: coef_cfg  = data[wes_pkg::COEF_W-1:0];
			wes_pkg::REG_FIRST_STEP:  first_cfg = data[0];
			default: ;
		endcase
	endtask

	// Wait until every request is taken and every result is back
	task automatic drain();
		do
			@(negedge clk);
		while (req_queue.size() != 0 || sample_valid || cell_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_sample(input wes_pkg::val_t cur, input wes_pkg::val_t prv);
		wave_req_t rq;
		rq.flush = 1'b0;
		rq.cur   = cur;
		rq.prv   = prv;
		req_queue.push_back(rq);
	endtask

	task automatic push_flush();
		wave_req_t rq;
		rq.flush = 1'b1;
		rq.cur   = wes_pkg::val_t'($urandom);
		rq.prv   = wes_pkg::val_t'($urandom);
		req_queue.push_back(rq);
	endtask

	function automatic wes_pkg::val_t pick_value();
		case ($urandom_range(0, 9))
			0:       return V_MAX;
			1:       return V_MIN;
			2:       return wes_pkg::val_t'($urandom_range(0, 1) ? 0 : -1);
			3, 4, 5: return wes_pkg::val_t'($urandom_range(0, 2 * 1048576))
				- wes_pkg::val_t'(1048576);
			default: return wes_pkg::val_t'($urandom);
		endcase
	endfunction

	function automatic wes_pkg::coef_t pick_coef();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return wes_pkg::COEF_RST;
			3:       return wes_pkg::coef_t'($urandom_range(0, 65535));
			default: return wes_pkg::coef_t'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_grid();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return $urandom_range(0, 2);
		if (sel < 4)
			return $urandom_range(7, 12);
		return $urandom_range(3, 6);
	endfunction

	// One frame with random content; may be cut short or carry noise.
	// Returns 1 when the frame was left open and needs a grid write.
	task automatic push_frame(output logic left_open);
		int unsigned n, total, split, stop, extra;
		n     = grid_used();
		total = n * n;
		split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, total - 1) : 0;
		stop  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total - 1) : total;
		for (int unsigned i = 0; i < stop; i++) begin
			// weight or mode change in the middle of a frame
			if (split != 0 && i == split) begin
				drain();
				write_reg(wes_pkg::REG_COEFFICIENT, wes_pkg::CFG_W'(pick_coef()));
				write_reg(wes_pkg::REG_FIRST_STEP,
					wes_pkg::CFG_W'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 29) == 0)
				push_flush();
			push_sample(pick_value(), pick_value());
			random_items++;
		end
		left_open = (stop < total);
		if (left_open)
			return;
		// samples past a full frame are dropped
		if ($urandom_range(0, 4) == 0) begin
			extra = $urandom_range(1, 3);
			repeat (extra) push_sample(pick_value(), pick_value());
		end
		repeat (n) push_flush();
		random_items += n;
		if ($urandom_range(0, 4) == 0)
			push_flush();
	endtask

	// Stimulus sequence
	initial begin
		logic needs_grid;
		for (int i = 0; i < GRID_MAX; i++) begin
			field_rows[0][i] = '0;
			field_rows[1][i] = '0;
			prev_line[i]     = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: clamped 3x3 grid, full weight, saturation both ways
		write_reg(wes_pkg::REG_GRID_SIZE, wes_pkg::CFG_W'(0));
		write_reg(wes_pkg::REG_COEFFICIENT, '1);
		write_reg(wes_pkg::REG_FIRST_STEP, wes_pkg::CFG_W'(0));
		push_flush();
		for (int i = 0; i < 9; i++)
			push_sample((i == 4) ? V_MAX : V_MIN, (i == 4) ? V_MIN : wes_pkg::val_t'(i));
		push_sample(V_MAX, V_MAX);
		repeat (3) push_flush();
		push_flush();
		drain();
		write_reg(wes_pkg::REG_GRID_SIZE, wes_pkg::CFG_W'(2));
		write_reg(wes_pkg::REG_FIRST_STEP, wes_pkg::CFG_W'(1));
		for (int i = 0; i < 9; i++)
			push_sample((i == 4) ? V_MIN : V_MAX, wes_pkg::val_t'(-1));
		repeat (3) push_flush();
		drain();

		// Oversized grid clamps to the largest; left open in the second row
		write_reg(wes_pkg::REG_COEFFICIENT, wes_pkg::CFG_W'(pick_coef()));
		write_reg(wes_pkg::REG_FIRST_STEP, wes_pkg::CFG_W'(0));
		write_reg(wes_pkg::REG_GRID_SIZE, wes_pkg::CFG_W'(2047));
		repeat (GRID_MAX + 6) push_sample(pick_value(), pick_value());
		drain();

		// Random frames, mostly well formed
		needs_grid = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			if (needs_grid || $urandom_range(0, 1) == 0)
				write_reg(wes_pkg::REG_GRID_SIZE, wes_pkg::CFG_W'(pick_grid()));
			if ($urandom_range(0, 2) == 0)
				write_reg(wes_pkg::REG_COEFFICIENT, wes_pkg::CFG_W'(pick_coef()));
			if ($urandom_range(0, 3) == 0)
				write_reg(wes_pkg::REG_FIRST_STEP, wes_pkg::CFG_W'($urandom_range(0, 1)));
			push_frame(needs_grid);
			drain();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Run limit
	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/wes_pkg.sv
hdl/wes_ctrl.sv
hdl/wes_line_mem.sv
hdl/wes_datapath.sv
hdl/wave_equation_stencil_step_top.sv
test/tb_wave_equation_stencil_step_top.sv
